@@ rtl/kemf_pkg.sv @@
// Package for the key event macro filter.
// Holds payload structs, action and register codes, and the controller/datapath command types.
// No dependencies; every other file of the block refers to it by scoped names.
package kemf_pkg;

    // Default sizes of the macro table and of the last-fire time store.
    localparam int MAX_MACROS_DEF  = 16;
    localparam int DEDUP_CODES_DEF = 256;

    // Reset value of the duplicate window, in 100 ns units.
    localparam logic [31:0] DEDUP_RESET = 32'd150000;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MACRO_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_WINDOW = 2'd1;

    // Item kinds on the input channel.
    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_TABLE = 1'b1;

    // Result actions.
    typedef logic [1:0] t_action;
    localparam t_action ACT_FORWARD   = 2'd0;
    localparam t_action ACT_DELIVER   = 2'd1;
    localparam t_action ACT_DUPLICATE = 2'd2;
    localparam t_action ACT_NO_READER = 2'd3;

    // Input item.
    typedef struct packed {
        logic        kind;
        logic [15:0] key_code;
        logic [15:0] key_flags;
        logic [63:0] now_time;
        logic        reader_waiting;
        logic [3:0]  table_index;
        logic [15:0] table_code;
    } t_key_in;

    // Result item.
    typedef struct packed {
        t_action     action;
        logic [15:0] out_code;
        logic [15:0] out_flags;
    } t_key_out;

    // Configuration write.
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          wdata;
    } t_cfg_wr;

    // Which decision the datapath latches as the result action.
    typedef enum logic [1:0] {
        RES_NONE,
        RES_SCAN,
        RES_TIME
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     clr_run;
        logic     tbl_wr;
        logic     capture;
        logic     scan_start;
        logic     scan_run;
        logic     time_rd;
        logic     time_wr;
        t_res_sel res_sel;
        logic     load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic hit;
        logic in_dedup;
        logic dup;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/kemf_if.sv @@
// Valid/ready channel interfaces of the key event macro filter.
// Depends on kemf_pkg for the payload structs.

// Input items: key records and macro table writes.
interface kemf_in_if;
    logic             valid;
    logic             ready;
    kemf_pkg::t_key_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result items.
interface kemf_out_if;
    logic              valid;
    logic              ready;
    kemf_pkg::t_key_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration register writes.
interface kemf_cfg_if;
    logic             valid;
    logic             ready;
    kemf_pkg::t_cfg_wr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/kemf_ctrl.sv @@
// Controller state machine of the key event macro filter.
// Sequences the clearing pass, the table scan, the time check and the result load.
// Depends on kemf_pkg for the command and status structs.
module kemf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_ready,
    input  kemf_pkg::t_dp_sts i_sts,
    output kemf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   w_in_xfer;

    assign w_in_xfer  = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    // Next state and commands for the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_sel = kemf_pkg::RES_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_run = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in_kind == kemf_pkg::KIND_TABLE) begin
                        o_cmd.tbl_wr = 1'b1;
                    end else begin
                        o_cmd.capture    = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.hit && i_sts.in_dedup) begin
                        o_cmd.time_rd = 1'b1;
                        n_state       = S_CHECK;
                    end else begin
                        o_cmd.res_sel = kemf_pkg::RES_SCAN;
                        n_state       = S_DONE;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.res_sel = kemf_pkg::RES_TIME;
                o_cmd.time_wr = !i_sts.dup;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered input ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

@@ rtl/kemf_dp.sv @@
// Datapath of the key event macro filter.
// Holds the configuration registers, macro table memory, last-fire time memory and
// the output register. Depends on kemf_pkg; driven by commands from kemf_ctrl.
module kemf_dp #(
    parameter int MAX_MACROS  = kemf_pkg::MAX_MACROS_DEF,
    parameter int DEDUP_CODES = kemf_pkg::DEDUP_CODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kemf_pkg::t_key_in  i_in_data,
    input  logic               i_cfg_we,
    input  kemf_pkg::t_cfg_wr  i_cfg_data,
    input  kemf_pkg::t_dp_cmd  i_cmd,
    output kemf_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kemf_pkg::t_key_out o_out_data
);

    localparam int TBL_AW = (MAX_MACROS > 1) ? $clog2(MAX_MACROS) : 1;
    localparam int CNT_W  = $clog2(MAX_MACROS + 1);
    localparam int LIM_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam int TAW    = (DEDUP_CODES > 1) ? $clog2(DEDUP_CODES) : 1;

    // Configuration registers.
    logic [4:0]  r_macro_count;
    logic [31:0] r_dedup_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_macro_count  <= '0;
            r_dedup_window <= kemf_pkg::DEDUP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_data.index)
                kemf_pkg::CFG_MACRO_COUNT:  r_macro_count  <= i_cfg_data.wdata[4:0];
                kemf_pkg::CFG_DEDUP_WINDOW: r_dedup_window <= i_cfg_data.wdata;
                default: begin
                end
            endcase
        end
    end

    // Captured key record.
    logic [15:0] r_code;
    logic [15:0] r_flags;
    logic [63:0] r_now;
    logic        r_reader;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code   <= i_in_data.key_code;
            r_flags  <= i_in_data.key_flags;
            r_now    <= i_in_data.now_time;
            r_reader <= i_in_data.reader_waiting;
        end
    end

    // Macro table memory; writes beyond the table are ignored.
    logic [15:0]       r_tbl_mem [MAX_MACROS];
    logic [15:0]       r_tbl_q;
    logic [LIM_W-1:0]  w_tidx_ext;
    logic              w_tidx_ok;

    assign w_tidx_ext = LIM_W'(i_in_data.table_index);
    assign w_tidx_ok  = w_tidx_ext < LIM_W'(MAX_MACROS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr && w_tidx_ok) begin
            r_tbl_mem[w_tidx_ext[TBL_AW-1:0]] <= i_in_data.table_code;
        end
    end

    // Scan limit: the entry count saturates at the table size.
    logic [LIM_W-1:0] w_cnt_ext;
    logic [LIM_W-1:0] w_limit;
    logic [CNT_W-1:0] r_scan_idx;
    logic             r_cmp_vld;
    logic             r_hit;
    logic             w_issue;

    assign w_cnt_ext = LIM_W'(r_macro_count);
    assign w_limit   = (w_cnt_ext > LIM_W'(MAX_MACROS)) ? LIM_W'(MAX_MACROS) : w_cnt_ext;
    assign w_issue   = LIM_W'(r_scan_idx) < w_limit;

    // Table read, one entry per cycle; the compare runs in the cycle after the read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && w_issue) begin
            r_tbl_q <= r_tbl_mem[r_scan_idx[TBL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_cmp_vld <= w_issue;
            if (w_issue) begin
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
            if (r_cmp_vld && (r_tbl_q == r_code)) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Clearing pass over the last-fire time memory after reset.
    logic [TAW-1:0] r_clr_idx;
    logic           w_clr_last;

    assign w_clr_last = (r_clr_idx == TAW'(DEDUP_CODES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_run && !w_clr_last) begin
            r_clr_idx <= r_clr_idx + TAW'(1);
        end
    end

    // Last-fire time memory: one write port, one registered read port.
    logic [63:0]    r_time_mem [DEDUP_CODES];
    logic [63:0]    r_time_q;
    logic [TAW-1:0] w_time_addr;
    logic           w_in_dedup;
    logic [63:0]    w_elapsed;
    logic           w_dup;

    assign w_time_addr = r_code[TAW-1:0];
    assign w_in_dedup  = {1'b0, r_code} < 17'(DEDUP_CODES);
    assign w_elapsed   = r_now - r_time_q;
    assign w_dup       = w_elapsed < {32'd0, r_dedup_window};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_run) begin
            r_time_mem[r_clr_idx] <= '0;
        end else if (i_cmd.time_wr) begin
            r_time_mem[w_time_addr] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.time_rd) begin
            r_time_q <= r_time_mem[w_time_addr];
        end
    end

    // Result action.
    kemf_pkg::t_action r_action;
    kemf_pkg::t_action w_reader_act;

    assign w_reader_act = r_reader ? kemf_pkg::ACT_DELIVER : kemf_pkg::ACT_NO_READER;

    always_ff @(posedge i_clk) begin
        case (i_cmd.res_sel)
            kemf_pkg::RES_SCAN: r_action <= r_hit ? w_reader_act : kemf_pkg::ACT_FORWARD;
            kemf_pkg::RES_TIME: r_action <= w_dup ? kemf_pkg::ACT_DUPLICATE : w_reader_act;
            default: begin
            end
        endcase
    end

    // Output register; it frees up in the cycle its transfer completes.
    logic               r_out_vld;
    kemf_pkg::t_key_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.action    <= r_action;
            r_out.out_code  <= r_code;
            r_out.out_flags <= r_flags;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Status back to the controller.
    assign o_sts.clr_last  = w_clr_last;
    assign o_sts.scan_done = !w_issue && !r_cmp_vld;
    assign o_sts.hit       = r_hit;
    assign o_sts.in_dedup  = w_in_dedup;
    assign o_sts.dup       = w_dup;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

endmodule

@@ rtl/key_event_macro_filter_core.sv @@
// Top level of the key event macro filter.
// Joins kemf_ctrl and kemf_dp to the channel interfaces of kemf_if.sv; uses kemf_pkg.

// After reset the block clears its last-fire time store, one entry per cycle, and
// accepts no input item meanwhile (configuration writes are taken at any time). After
// a macro table write the block stays ready for the next item. For a key record the
// macro table scan reads one entry per cycle from the table memory and compares it in
// the cycle after the read. A hit on a code below DEDUP_CODES then passes through the
// last-fire time check, the result is loaded into the output register, and the next
// input item is taken in the cycle after that load. The load waits while a full output
// register has not been taken. Each key record gives exactly one result; the next item
// is accepted while that result waits in the output register.
module key_event_macro_filter_core #(
    parameter int MAX_MACROS  = kemf_pkg::MAX_MACROS_DEF,
    parameter int DEDUP_CODES = kemf_pkg::DEDUP_CODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kemf_in_if.sink     i_in,
    kemf_out_if.source  o_out,
    kemf_cfg_if.sink    i_cfg
);

    kemf_pkg::t_dp_cmd w_cmd;
    kemf_pkg::t_dp_sts w_sts;
    logic              w_in_ready;
    logic              w_cfg_we;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;
    assign i_in.ready  = w_in_ready;

    kemf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.data.kind),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    kemf_dp #(
        .MAX_MACROS  (MAX_MACROS),
        .DEDUP_CODES (DEDUP_CODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

    // A key record transfer starts a scan, so no further item is taken next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.data.kind == kemf_pkg::KIND_KEY))
            |=> !i_in.ready)
        else $error("input accepted while a key record is in work");

    // A result is loaded only into a free output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("result loaded over a pending output");

    // The last-fire time is written only for a code inside the store that is not a duplicate.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.time_wr |-> (w_sts.in_dedup && !w_sts.dup && !w_cmd.clr_run))
        else $error("last-fire time written for a swallowed or untracked code");

endmodule
